FILE: rtl/core/lru_key_value_cache_macros.svh
// Assertion macros shared by the LRU key/value cache RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH
`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define LKV_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Checks that a condition in one cycle implies another in the next cycle.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LKV_ASSERT(label, expr, msg)
`define LKV_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/lkv_pkg.sv
// Shared constants and types of the LRU key/value cache.
// No dependencies; every module of the block and its testbench import this package.
`default_nettype none
package lkv_pkg;
	localparam int MaxEntries = 16;
	localparam int KeyW = 32;
	localparam int ValW = 32;
	localparam int CapW = 5;
	localparam int OccW = $clog2(MaxEntries + 1);
	localparam int CmpW = (OccW > CapW) ? OccW : CapW;
	localparam int PAddrW = 2;
	localparam int PDataW = 32;
	localparam logic [CapW-1:0] CapReset = CapW'(16);
	localparam logic [PAddrW-1:0] AddrCapacity = PAddrW'(0);

	// One entry of the recency row.
	typedef struct packed {
		logic            valid;
		logic [KeyW-1:0] key;
		logic [ValW-1:0] value;
	} entry_t;

	// Command from the controller to the row of cells.
	typedef struct packed {
		logic [MaxEntries-1:0] shift;
		logic                  hit;
	} cmd_t;
endpackage
`default_nettype wire

FILE: rtl/core/lkv_cell.sv
// One recency position of the LRU row: holds an entry and compares it to the probe key.
// Depends on lkv_pkg.
`default_nettype none
module lkv_cell import lkv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  entry_t          entry_in,
	input  logic [KeyW-1:0] probe_key,
	output entry_t          entry,
	output logic            match
);
	logic            valid_q;
	logic [KeyW-1:0] key_q;
	logic [ValW-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= entry_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= entry_in.key;
			value_q <= entry_in.value;
		end
	end

	assign entry = '{valid: valid_q, key: key_q, value: value_q};
	assign match = valid_q && (key_q == probe_key);
endmodule
`default_nettype wire

FILE: rtl/core/lkv_ctrl.sv
// Controller of the LRU row: picks the hit entry, builds the shift mask and tracks occupancy.
// Depends on lkv_pkg and lru_key_value_cache_macros.svh.
`default_nettype none
`include "lru_key_value_cache_macros.svh"
module lkv_ctrl import lkv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CapW-1:0]       cap,
	input  logic                  req_valid,
	input  logic                  req_put,
	input  logic [KeyW-1:0]       req_key,
	input  logic [ValW-1:0]       req_value,
	input  entry_t [MaxEntries-1:0] entries,
	input  logic [MaxEntries-1:0] match,
	output cmd_t                  cmd,
	output entry_t                head,
	output logic [ValW-1:0]       rd_value
);
	logic [OccW-1:0]       occ_q;
	logic [OccW-1:0]       occ_inc;
	logic                  hit;
	logic                  full;
	logic                  fill;
	logic [CmpW-1:0]       eff_cap;
	logic [KeyW-1:0]       sel_key;
	logic [ValW-1:0]       sel_value;
	logic [MaxEntries-1:0] hit_mask;
	logic [MaxEntries-1:0] miss_mask;

	assign hit = |match;

	// Keys in the row are unique, so the match vector selects at most one entry.
	always_comb begin
		sel_key   = '0;
		sel_value = '0;
		for (int i = 0; i < MaxEntries; i++) begin
			sel_key   = sel_key | (entries[i].key & {KeyW{match[i]}});
			sel_value = sel_value | (entries[i].value & {ValW{match[i]}});
		end
	end

	// A capacity of zero acts as one; one above the row length saturates.
	always_comb begin
		eff_cap = CmpW'(cap);
		if (eff_cap == '0) begin
			eff_cap = CmpW'(1);
		end else if (eff_cap > CmpW'(MaxEntries)) begin
			eff_cap = CmpW'(MaxEntries);
		end
	end

	assign full = CmpW'(occ_q) >= eff_cap;

	// A put miss below capacity fills the first free position and grows the occupancy.
	assign fill    = req_valid && req_put && !hit && !full;
	assign occ_inc = occ_q + OccW'(1);

	// A hit shifts every position up to the hit; a miss shifts up to the last valid
	// entry when full (evicting it) or up to the first free position otherwise.
	for (genvar i = 0; i < MaxEntries; i++) begin : g_mask
		assign hit_mask[i]  = |match[MaxEntries-1:i];
		assign miss_mask[i] = full ? (OccW'(i) < occ_q) : (OccW'(i) <= occ_q);
	end

	always_comb begin
		cmd.hit = hit;
		if (!req_valid) begin
			cmd.shift = '0;
		end else if (hit) begin
			cmd.shift = hit_mask;
		end else if (req_put) begin
			cmd.shift = miss_mask;
		end else begin
			cmd.shift = '0;
		end
	end

	always_comb begin
		head.valid = 1'b1;
		if (hit) begin
			head.key   = sel_key;
			head.value = req_put ? req_value : sel_value;
		end else begin
			head.key   = req_key;
			head.value = req_value;
		end
	end

	assign rd_value = (hit && !req_put) ? sel_value : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (fill) begin
			occ_q <= occ_inc;
		end
	end

	`LKV_ASSERT(a_match_onehot, $onehot0(match), "more than one cell matches the key")
	`LKV_ASSERT(a_occ_bound, occ_q <= OccW'(MaxEntries), "occupancy exceeds the row length")
	`LKV_ASSERT_NEXT(a_occ_grow, fill, occ_q == $past(occ_inc), "occupancy did not grow on a fill")
	`LKV_ASSERT_NEXT(a_occ_hold, req_valid && hit, occ_q == $past(occ_q), "a hit changed occupancy")
endmodule
`default_nettype wire

FILE: rtl/core/lru_key_value_cache.sv
// Top level of the LRU key/value cache: request stage, capacity register, row of cells.
// Depends on lkv_pkg, lkv_cell and lkv_ctrl.
//
// A fully associative key/value cache with least-recently-used replacement. A transaction
// is accepted at a rising edge where start is high and busy is low; busy stays low, so
// one get or put can be issued in every cycle. The accepted request is registered, then
// compared against all valid entries in parallel during the following cycle, and the row
// of cells performs its move-to-front at the end of that cycle. The result is shown on
// hit and read_value for exactly one cycle, flagged by done, out of the result register.
// The receiver cannot stall the block, so the result must be captured in that cycle.
// Sustained rate is one transaction per cycle; the cell row updates at the end of each
// compare cycle, so each lookup sees the row as the previous transaction left it.
// A get hit returns the stored value and makes the entry most recent; a put hit overwrites
// the value and makes it most recent; a put miss inserts the entry as most recent, evicting
// the least recent entry once occupancy reaches the capacity register. Gets that miss and
// all puts return zero on read_value. The capacity register lies at byte address zero of
// the APB port; zero acts as one and values above sixteen act as sixteen. Lowering it
// below the occupancy keeps every entry; each put miss then replaces the least recent one.
// Write the capacity only while no transaction is in flight.
`default_nettype none
module lru_key_value_cache import lkv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     action,
	input  logic signed [KeyW-1:0]   key,
	input  logic signed [ValW-1:0]   write_value,
	output logic                     done,
	output logic                     hit,
	output logic signed [ValW-1:0]   read_value,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PAddrW-1:0]        paddr,
	input  logic [PDataW-1:0]        pwdata,
	output logic [PDataW-1:0]        prdata,
	output logic                     pready
);
	logic                  valid_s1;
	logic                  put_s1;
	logic [KeyW-1:0]       key_s1;
	logic [ValW-1:0]       value_s1;
	logic [CapW-1:0]       cap_q;
	logic                  done_q;
	logic                  hit_q;
	logic [ValW-1:0]       read_value_q;
	entry_t [MaxEntries-1:0] entries;
	logic [MaxEntries-1:0] match;
	cmd_t                  cmd;
	entry_t                head;
	logic [ValW-1:0]       rd_value;

	// The block takes a new request in every cycle.
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// Capacity register; written on the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (psel && penable && pwrite && pready && (paddr == AddrCapacity)) begin
			cap_q <= pwdata[CapW-1:0];
		end
	end

	assign prdata = (paddr == AddrCapacity) ? PDataW'(cap_q) : '0;

	// Request stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			put_s1   <= action;
			key_s1   <= $unsigned(key);
			value_s1 <= $unsigned(write_value);
		end
	end

	// Row of cells: position zero is most recent, each cell loads from its left neighbor.
	for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
		entry_t cell_in;
		if (i == 0) begin : g_head
			assign cell_in = head;
		end else begin : g_link
			assign cell_in = entries[i-1];
		end
		lkv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (cmd.shift[i]),
			.entry_in  (cell_in),
			.probe_key (key_s1),
			.entry     (entries[i]),
			.match     (match[i])
		);
	end

	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.req_valid (valid_s1),
		.req_put   (put_s1),
		.req_key   (key_s1),
		.req_value (value_s1),
		.entries   (entries),
		.match     (match),
		.cmd       (cmd),
		.head      (head),
		.rd_value  (rd_value)
	);

	// Result register; the result strobe lasts one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hit_q        <= cmd.hit;
			read_value_q <= rd_value;
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign read_value = $signed(read_value_q);
endmodule
`default_nettype wire

FILE: tb/sv/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key/value cache: directed and random get/put traffic.
// Depends on lkv_pkg for port widths and the APB address of the capacity register.
// Predicts every lookup with an in-bench recency model and checks hit and read_value.
module tb_lru_key_value_cache import lkv_pkg::*;;

	// Depth of the modeled store and the capacity the block comes out of reset with.
	localparam int Depth = 16;
	localparam int CapAtReset = 16;
	// Generous cycle budget; the watchdog ends a run that exceeds it.
	localparam int CycleLimit = 400000;
	localparam int RandomPhases = 10;
	localparam int ItemsPerPhase = 173;

	typedef enum logic {OpGet = 1'b0, OpPut = 1'b1} op_e;

	// One queued request, with the number of idle cycles the driver waits before it.
	typedef struct {
		op_e             op;
		logic [KeyW-1:0] key;
		logic [ValW-1:0] value;
		int              gap;
	} request_t;

	// What the block must report for one accepted request.
	typedef struct {
		logic            hit;
		logic [ValW-1:0] value;
	} lookup_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic                   action = 1'b0;
	logic signed [KeyW-1:0] key = '0;
	logic signed [ValW-1:0] write_value = '0;
	logic                   done;
	logic                   hit;
	logic signed [ValW-1:0] read_value;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [PAddrW-1:0]      paddr = '0;
	logic [PDataW-1:0]      pwdata = '0;
	logic [PDataW-1:0]      prdata;
	logic                   pready;

	// Requests waiting to be driven, and lookups predicted but not yet reported.
	request_t request_queue[$];
	lookup_t  lookups_due[$];

	// Recency model of the cache. age_order[p] names the line at recency position p,
	// position zero being the most recent; positions below lines_used hold valid lines.
	logic [KeyW-1:0] line_key[Depth];
	logic [ValW-1:0] line_value[Depth];
	logic            line_valid[Depth];
	int unsigned     age_order[Depth];
	int unsigned     lines_used;
	logic [CapW-1:0] capacity_setting;

	int mismatches = 0;
	int results_seen = 0;
	int cycle_count = 0;
	int max_gap = 0;

	lru_key_value_cache i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.key         (key),
		.write_value (write_value),
		.done        (done),
		.hit         (hit),
		.read_value  (read_value),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #10 clk = ~clk;

	// Moves the line at recency position pos to the front, shifting the younger ones back.
	function automatic void move_to_front(input int unsigned pos);
		int unsigned line;
		int unsigned p;
		line = age_order[pos];
		for (p = pos; p > 0; p--) begin
			age_order[p] = age_order[p - 1];
		end
		age_order[0] = line;
	endfunction

	// Applies one request to the recency model and returns what the block must report.
	// A zero capacity behaves as one, and anything above the depth behaves as the depth.
	// When the capacity was lowered below the occupancy, a put miss replaces the least
	// recent line in place, so the occupancy never shrinks.
	function automatic lookup_t cache_lookup(input op_e op, input logic [KeyW-1:0] k,
			input logic [ValW-1:0] v);
		lookup_t     res;
		int          pos;
		int unsigned p;
		int unsigned usable;
		res.hit = 1'b0;
		res.value = '0;
		pos = -1;
		for (p = 0; p < lines_used; p++) begin
			if (pos < 0 && line_valid[age_order[p]] && line_key[age_order[p]] == k) begin
				pos = p;
			end
		end
		res.hit = (pos >= 0);
		if (res.hit) begin
			if (op == OpGet) begin
				res.value = line_value[age_order[pos]];
			end else begin
				line_value[age_order[pos]] = v;
			end
			move_to_front(pos);
		end else if (op == OpPut) begin
			usable = (capacity_setting == 0) ? 1 : capacity_setting;
			if (usable > Depth) begin
				usable = Depth;
			end
			if (lines_used >= usable) begin
				p = lines_used - 1;
			end else begin
				p = lines_used;
				lines_used++;
			end
			line_key[age_order[p]] = k;
			line_value[age_order[p]] = v;
			line_valid[age_order[p]] = 1'b1;
			move_to_front(p);
		end
		return res;
	endfunction

	// Counts a failure; only the first ten are described in the log.
	function automatic void flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("result %0d: %s expected %h, got %h", results_seen, what, want, got);
		end
	endfunction

	// Request driver. A transaction is accepted at an edge where start is high and busy
	// is low; the prediction is made right there, from the fields as they were driven.
	// The next request goes out once its gap of idle cycles has passed, so a gap of zero
	// keeps start high across back-to-back transactions with a single assignment.
	always @(posedge clk) begin : drive_requests
		request_t    req;
		logic        launch;
		int          idle_cycles;
		launch = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				lookups_due.push_back(cache_lookup(op_e'(action), key, write_value));
				idle_cycles = 0;
			end
			if (start && busy) begin
				launch = 1'b1;
			end else if (request_queue.size() != 0 && idle_cycles >= request_queue[0].gap) begin
				req = request_queue.pop_front();
				action <= req.op;
				key <= req.key;
				write_value <= req.value;
				launch = 1'b1;
			end else begin
				idle_cycles++;
			end
		end else begin
			idle_cycles = 0;
		end
		start <= launch;
	end

	// Result monitor. The strobe lasts one cycle and cannot be held off, so every edge
	// with done high carries a result that must match the oldest prediction.
	always @(posedge clk) begin : check_results
		lookup_t want;
		if (arst_n && done) begin
			results_seen++;
			if (lookups_due.size() == 0) begin
				flag_mismatch("unrequested result, hit/read_value", '0, {hit, read_value[30:0]});
			end else begin
				want = lookups_due.pop_front();
				if (hit !== want.hit) begin
					flag_mismatch("hit", want.hit, hit);
				end
				if (read_value !== want.value) begin
					flag_mismatch("read_value", want.value, read_value);
				end
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic queue_request(input op_e op, input logic [KeyW-1:0] k,
			input logic [ValW-1:0] v);
		request_t req;
		req.op = op;
		req.key = k;
		req.value = v;
		req.gap = $urandom_range(0, max_gap);
		request_queue.push_back(req);
	endtask

	// Returns at a falling edge once nothing is queued, driven or outstanding. Sampling
	// on the falling edge keeps the check clear of the driver's updates at the rising one.
	task automatic wait_for_drain();
		@(negedge clk);
		while (request_queue.size() != 0 || start || lookups_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// APB read of the capacity register in a setup and an access cycle.
	task automatic check_capacity_readback(input logic [CapW-1:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= AddrCapacity;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== PDataW'(want)) begin
			flag_mismatch("capacity readback", PDataW'(want), prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// APB write of the capacity register. The upper data bits are random and must be
	// dropped by the register. Only called while the block is idle.
	task automatic set_capacity(input logic [CapW-1:0] cap);
		logic [PDataW-1:0] word;
		word = $urandom();
		word[CapW-1:0] = cap;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrCapacity;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		capacity_setting = cap;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		check_capacity_readback(cap);
	endtask

	initial begin
		logic [CapW-1:0] phase_caps[RandomPhases];
		logic [KeyW-1:0] key_pool[$];
		int              pool_size;
		int              usable;
		int              phase;
		int              n;
		logic [KeyW-1:0] k;

		for (n = 0; n < Depth; n++) begin
			line_key[n] = '0;
			line_value[n] = '0;
			line_valid[n] = 1'b0;
			age_order[n] = n;
		end
		lines_used = 0;
		capacity_setting = CapW'(CapAtReset);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		check_capacity_readback(CapW'(CapAtReset));

		// Directed part at the reset capacity: a miss on the empty store, the extreme
		// keys and values, a put hit that overwrites, and gets whose write_value is ignored.
		max_gap = 0;
		queue_request(OpGet, 32'h8000_0000, 32'hdead_beef);
		queue_request(OpPut, 32'h8000_0000, 32'h7fff_ffff);
		queue_request(OpPut, 32'h7fff_ffff, 32'h8000_0000);
		queue_request(OpPut, 32'h0000_0000, 32'h0000_0000);
		queue_request(OpPut, 32'hffff_ffff, 32'hffff_ffff);
		queue_request(OpGet, 32'h8000_0000, 32'h0000_0000);
		queue_request(OpGet, 32'h7fff_ffff, 32'hffff_ffff);
		max_gap = 8;
		queue_request(OpPut, 32'h0000_0000, 32'h5a5a_a5a5);
		queue_request(OpGet, 32'h0000_0000, 32'h0000_0000);
		queue_request(OpGet, 32'h0000_0001, 32'h0000_0000);
		queue_request(OpGet, 32'hffff_fffe, 32'h0000_0000);
		wait_for_drain();

		// Capacity lowered below the four lines in use: misses now replace the least
		// recent line one at a time while the occupancy stays put.
		set_capacity(CapW'(2));
		queue_request(OpPut, 32'h0000_0001, 32'h1111_1111);
		queue_request(OpGet, 32'hffff_ffff, 32'h0000_0000);
		queue_request(OpGet, 32'h8000_0000, 32'h0000_0000);
		queue_request(OpPut, 32'h0001_0000, 32'h0000_0002);
		queue_request(OpGet, 32'h7fff_ffff, 32'h0000_0000);
		queue_request(OpGet, 32'h0000_0001, 32'h0000_0000);
		wait_for_drain();

		// A capacity of zero acts as one.
		set_capacity(CapW'(0));
		queue_request(OpPut, 32'ha5a5_a5a5, 32'h0000_0003);
		queue_request(OpPut, 32'h5a5a_5a5a, 32'h0000_0004);
		queue_request(OpGet, 32'ha5a5_a5a5, 32'h0000_0000);
		queue_request(OpGet, 32'h5a5a_5a5a, 32'h0000_0000);
		wait_for_drain();

		// Random phases. Each uses its own capacity and a pool of keys sized around it,
		// so gets and puts see a steady mix of hits, misses and evictions; a few keys are
		// drawn fresh. The store drains before every capacity change, which also makes
		// the sender pause until every expected result has come.
		phase_caps = '{CapW'(16), CapW'(1), CapW'(31), CapW'(5), CapW'(0), CapW'(12),
			CapW'(2), CapW'(16), CapW'($urandom_range(1, 16)), CapW'($urandom_range(0, 31))};
		for (phase = 0; phase < RandomPhases; phase++) begin
			set_capacity(phase_caps[phase]);
			usable = (phase_caps[phase] == 0) ? 1 : phase_caps[phase];
			if (usable > Depth) begin
				usable = Depth;
			end
			pool_size = $urandom_range(2, 2 * usable + 3);
			key_pool.delete();
			for (n = 0; n < pool_size; n++) begin
				key_pool.push_back($urandom());
			end
			for (n = 0; n < ItemsPerPhase; n++) begin
				// Idling comes in stretches: none at all, short gaps, or full-range gaps.
				if (n % 25 == 0) begin
					case ($urandom_range(0, 2))
						0: begin
							max_gap = 0;
						end
						1: begin
							max_gap = 2;
						end
						default: begin
							max_gap = 8;
						end
					endcase
				end
				if ($urandom_range(0, 99) < 85) begin
					k = key_pool[$urandom_range(0, pool_size - 1)];
				end else begin
					k = $urandom();
				end
				queue_request(op_e'($urandom_range(0, 1)), k, $urandom());
			end
			wait_for_drain();
		end

		// wait_for_drain already saw every result; the edges that follow still catch a stray
		// extra strobe, then anything left counts as missing.
		repeat (6) @(posedge clk);
		if (lookups_due.size() != 0) begin
			mismatches += lookups_due.size();
			$display("%0d predicted results never arrived", lookups_due.size());
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
